@@ hw/rtl/sng_pkg.sv @@
// sng_pkg: codes shared by the spectral noise gate and its testbench.
// No dependencies.
`timescale 1ns / 1ps

package sng_pkg;

  // pass kind carried in in_tuser
  localparam logic [1:0] OP_NOISE = 2'd0;
  localparam logic [1:0] OP_CMP   = 2'd1;
  localparam logic [1:0] OP_SRC   = 2'd2;
  localparam logic [1:0] OP_RSVD  = 2'd3;

  // clean_mode codes
  localparam logic [1:0] MODE_FILTER   = 2'd0;
  localparam logic [1:0] MODE_COMPARE  = 2'd1;
  localparam logic [1:0] MODE_ANYWHERE = 2'd2;
  localparam logic [1:0] MODE_FROMTIME = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_CLEAN_MODE   = 3'd0;
  localparam logic [2:0] REG_NOISE_GAIN   = 3'd1;
  localparam logic [2:0] REG_CUTOFF_BIN   = 3'd2;
  localparam logic [2:0] REG_SKIP_WINDOWS = 3'd3;
  localparam logic [2:0] REG_BIN_COUNT    = 3'd4;

  localparam int BIN_BITS = 10;
  localparam int CFG_BITS = 24;
  localparam int WIN_BITS = 24;
  localparam logic [WIN_BITS-1:0] WIN_MAX = {WIN_BITS{1'b1}};

endpackage

@@ hw/rtl/spectral_noise_gate.sv @@
// spectral_noise_gate: per-bin spectral noise gate, top level.
// Uses sng_pkg. Per-bin state lives in one internal memory.
//
//  channel | direction | handshake             | payload
//  in_     | slave     | in_tvalid / in_tready | tuser: opcode; tdata: bin_index, amplitude
//  out_    | master    | out_tvalid/out_tready | tdata: amplitude_out, gated, no_marks
//  cfg_    | write     | cfg_wen               | cfg_index, cfg_wdata
//
// One transfer per cycle while the output is not stalled; each item passes the memory read
// register, then the result register. The per-bin memory does one read-modify-write per item;
// a one-deep write bypass covers back-to-back items on the same bin.
// After reset a clearing pass initializes all MAX_BINS memory entries; in_tready is low
// meanwhile. Output stalls hold the result register and back up into the input stage.
`timescale 1ns / 1ps

module spectral_noise_gate #(
  parameter int MAX_BINS = 1024,
  parameter int AMP_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [9:0] bin_index, [10 +: AMP_BITS] amplitude, zero fill
  input  logic [((sng_pkg::BIN_BITS+AMP_BITS+7)/8)*8-1:0] in_tdata,
  // [1:0] opcode
  input  logic [1:0]                           in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [AMP_BITS-1:0] amplitude_out, [AMP_BITS] gated, [AMP_BITS+1] no_marks, zero fill
  output logic [((AMP_BITS+2+7)/8)*8-1:0]      out_tdata,
  input  logic                                 cfg_wen,
  input  logic [2:0]                           cfg_index,
  input  logic [sng_pkg::CFG_BITS-1:0]         cfg_wdata
);

  localparam int AW    = $clog2(MAX_BINS);
  localparam int NBW   = $clog2(MAX_BINS + 1);
  localparam int CW    = (NBW > 11) ? NBW : 11;
  localparam int MW    = AMP_BITS + 2;
  localparam int PW    = AMP_BITS + 16;
  localparam int OUT_W = ((AMP_BITS + 2 + 7) / 8) * 8;
  localparam int BB    = sng_pkg::BIN_BITS;

  // configuration
  logic [1:0]  clean_mode_r;
  logic [15:0] noise_gain_r;
  logic [10:0] cutoff_bin_r;
  logic [23:0] skip_windows_r;
  logic [10:0] bin_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clean_mode_r   <= sng_pkg::MODE_FILTER;
      noise_gain_r   <= 16'd256;
      cutoff_bin_r   <= '0;
      skip_windows_r <= '0;
      bin_count_r    <= 11'd1024;
    end else if (cfg_wen) begin
      case (cfg_index)
        sng_pkg::REG_CLEAN_MODE:   clean_mode_r   <= cfg_wdata[1:0];
        sng_pkg::REG_NOISE_GAIN:   noise_gain_r   <= cfg_wdata[15:0];
        sng_pkg::REG_CUTOFF_BIN:   cutoff_bin_r   <= cfg_wdata[10:0];
        sng_pkg::REG_SKIP_WINDOWS: skip_windows_r <= cfg_wdata[23:0];
        sng_pkg::REG_BIN_COUNT:    bin_count_r    <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  // per-bin memory: {peak, mark, latched}
  logic [MW-1:0] bin_mem [MAX_BINS];
  logic [MW-1:0] rd_data_r;
  logic          mem_wen;
  logic [AW-1:0] mem_waddr;
  logic [MW-1:0] mem_wdata;

  // clearing pass
  logic          clr_active_r;
  logic [AW-1:0] clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + AW'(1);
      if (clr_addr_r == AW'(MAX_BINS - 1)) clr_active_r <= 1'b0;
    end
  end

  // input stage
  logic            s1_valid_r;
  logic [1:0]      s1_op_r;
  logic [BB-1:0]   s1_bin_r;
  logic [AMP_BITS-1:0] s1_amp_r;
  logic            out_valid_r;
  logic            s1_adv;
  logic            in_acc;
  logic [BB-1:0]   in_bin;

  assign in_bin    = in_tdata[BB-1:0];
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !clr_active_r && (!s1_valid_r || s1_adv);
  assign in_acc    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (mem_wen) bin_mem[mem_waddr] <= mem_wdata;
    if (in_acc) rd_data_r <= bin_mem[AW'(in_bin)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r  <= in_tuser;
      s1_bin_r <= in_bin;
      s1_amp_r <= in_tdata[BB +: AMP_BITS];
    end
  end

  // bypass of the last write
  logic          fwd_vld_r;
  logic [BB-1:0] fwd_bin_r;
  logic [MW-1:0] fwd_data_r;

  // running state
  logic [NBW-1:0]              cleared_cnt_r;
  logic [sng_pkg::WIN_BITS-1:0] window_cnt_r;

  // item evaluation
  logic [MW-1:0]       cur;
  logic [MW-1:0]       nxt_entry;
  logic [AMP_BITS-1:0] peak;
  logic [PW-1:0]       thresh;
  logic [PW-1:0]       amp_sh;
  logic [NBW-1:0]      nbins;
  logic                in_use;
  logic                last_bin;
  logic                active;
  logic                below;
  logic                above;
  logic                gated;
  logic                no_marks;
  logic                clr_inc;
  logic                win_inc;

  always_comb begin
    cur       = (fwd_vld_r && fwd_bin_r == s1_bin_r) ? fwd_data_r : rd_data_r;
    peak      = cur[MW-1:2];
    thresh    = PW'(peak) * PW'(noise_gain_r);
    amp_sh    = PW'({s1_amp_r, 8'd0});
    below     = amp_sh < thresh;
    above     = amp_sh > thresh;
    nbins     = (CW'(bin_count_r) > CW'(MAX_BINS)) ? NBW'(MAX_BINS) : NBW'(bin_count_r);
    in_use    = CW'(s1_bin_r) < CW'(nbins);
    last_bin  = (CW'(s1_bin_r) + CW'(1)) == CW'(nbins);
    active    = window_cnt_r >= skip_windows_r;
    nxt_entry = cur;
    gated     = 1'b0;
    no_marks  = 1'b0;
    clr_inc   = 1'b0;
    win_inc   = 1'b0;
    if (in_use) begin
      case (s1_op_r)
        sng_pkg::OP_NOISE: begin
          if (s1_amp_r > peak) nxt_entry[MW-1:2] = s1_amp_r;
        end
        sng_pkg::OP_CMP: begin
          if (clean_mode_r == sng_pkg::MODE_COMPARE && cur[1] && above) begin
            nxt_entry[1] = 1'b0;
            clr_inc      = 1'b1;
          end
        end
        sng_pkg::OP_SRC: begin
          case (clean_mode_r)
            sng_pkg::MODE_FILTER: begin
              gated = (CW'(s1_bin_r) >= CW'(cutoff_bin_r)) && below;
            end
            sng_pkg::MODE_COMPARE: begin
              if (cleared_cnt_r >= nbins) no_marks = 1'b1;
              else gated = cur[1];
            end
            sng_pkg::MODE_ANYWHERE: begin
              gated = active && below;
            end
            default: begin
              gated = active && (cur[0] || below);
              if (gated) nxt_entry[0] = 1'b1;
            end
          endcase
          win_inc = last_bin && (window_cnt_r != sng_pkg::WIN_MAX);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    if (clr_active_r) begin
      mem_wen   = 1'b1;
      mem_waddr = clr_addr_r;
      mem_wdata = {{AMP_BITS{1'b0}}, 1'b1, 1'b0};
    end else begin
      mem_wen   = s1_adv && in_use;
      mem_waddr = AW'(s1_bin_r);
      mem_wdata = nxt_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_vld_r     <= 1'b0;
      cleared_cnt_r <= '0;
      window_cnt_r  <= '0;
    end else if (s1_adv) begin
      fwd_vld_r <= in_use;
      if (clr_inc) cleared_cnt_r <= cleared_cnt_r + NBW'(1);
      if (win_inc) window_cnt_r <= window_cnt_r + sng_pkg::WIN_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      fwd_bin_r  <= s1_bin_r;
      fwd_data_r <= nxt_entry;
    end
  end

  // result register
  logic [AMP_BITS-1:0] out_amp_r;
  logic                out_gated_r;
  logic                out_nomarks_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_amp_r     <= gated ? '0 : s1_amp_r;
      out_gated_r   <= gated;
      out_nomarks_r <= no_marks;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_nomarks_r, out_gated_r, out_amp_r});

endmodule

@@ hw/rtl/sng_checker.sv @@
// sng_checker: port-level checks for spectral_noise_gate, bound to the top level.
// Depends on the spectral_noise_gate port layout.
`timescale 1ns / 1ps

module sng_checker #(
  parameter int AMP_BITS = 24
) (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_tready,
  input logic                                 out_tvalid,
  input logic                                 out_tready,
  input logic [((AMP_BITS+2+7)/8)*8-1:0]      out_tdata
);

  // a gated result carries zero amplitude
  a_gated_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[AMP_BITS]) |-> (out_tdata[AMP_BITS-1:0] == '0))
    else $error("gated result with nonzero amplitude");

  // an item is never both gated and flagged for no marks
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[AMP_BITS] && out_tdata[AMP_BITS+1]))
    else $error("gated and no_marks both set");

  // the memory clearing pass keeps the input closed right after reset
  a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> (!in_tready && !out_tvalid))
    else $error("block open directly after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

endmodule

bind spectral_noise_gate sng_checker #(.AMP_BITS(AMP_BITS)) u_sng_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ verif/tb_spectral_noise_gate.sv @@
// tb_spectral_noise_gate: self-checking bench for the spectral noise gate.
// Drives tagged bin amplitudes through in_, checks every out_ transfer against
// an in-bench gate predictor. Depends on sng_pkg and spectral_noise_gate.
`timescale 1ns / 1ps

module tb_spectral_noise_gate;

  localparam int NBINS       = 1024;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [1:0]  op;
    logic [9:0]  bin;
    logic [23:0] amp;
  } bin_item_t;

  typedef struct packed {
    logic [23:0] amp;
    logic        gated;
    logic        no_marks;
  } gate_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;
  logic [1:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        cfg_wen = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [sng_pkg::CFG_BITS-1:0] cfg_wdata = '0;

  spectral_noise_gate dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_wen(cfg_wen), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // gate state as predicted
  logic [23:0] bin_peak [NBINS];
  bit          bin_armed [NBINS];
  bit          bin_stuck [NBINS];
  int unsigned disarmed_count;
  logic [sng_pkg::WIN_BITS-1:0] windows_seen;
  logic [1:0]  cur_mode;
  logic [15:0] cur_gain;
  logic [10:0] cur_cutoff;
  logic [23:0] cur_skip;
  logic [10:0] cur_bins;

  bin_item_t    bins_to_send [$];
  gate_result_t awaited_results [$];

  bit in_taken = 1'b0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int tx_idle = 0;
  int rx_idle = 0;
  int quiet_cycles = 0;
  int errors = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic gate_result_t gate_predict(bin_item_t it);
    int unsigned  nb;
    logic [47:0]  thr;
    logic [47:0]  scaled;
    bit           below;
    bit           active;
    gate_result_t r;
    nb = (cur_bins > NBINS) ? NBINS : cur_bins;
    r.amp = it.amp;
    r.gated = 1'b0;
    r.no_marks = 1'b0;
    thr = 48'(bin_peak[it.bin]) * 48'(cur_gain);
    scaled = 48'(it.amp) << 8;
    below = scaled < thr;
    if (it.bin < nb) begin
      case (it.op)
        sng_pkg::OP_NOISE: begin
          if (it.amp > bin_peak[it.bin]) bin_peak[it.bin] = it.amp;
        end
        sng_pkg::OP_CMP: begin
          if (cur_mode == sng_pkg::MODE_COMPARE && bin_armed[it.bin] && scaled > thr) begin
            bin_armed[it.bin] = 1'b0;
            disarmed_count++;
          end
        end
        sng_pkg::OP_SRC: begin
          active = windows_seen >= cur_skip;
          case (cur_mode)
            sng_pkg::MODE_FILTER: begin
              if (it.bin >= cur_cutoff && below) r.gated = 1'b1;
            end
            sng_pkg::MODE_COMPARE: begin
              if (disarmed_count >= nb) r.no_marks = 1'b1;
              else if (bin_armed[it.bin]) r.gated = 1'b1;
            end
            sng_pkg::MODE_ANYWHERE: begin
              if (active && below) r.gated = 1'b1;
            end
            default: begin
              if (active && (bin_stuck[it.bin] || below)) begin
                r.gated = 1'b1;
                bin_stuck[it.bin] = 1'b1;
              end
            end
          endcase
          if (r.gated) r.amp = '0;
          if (it.bin == nb - 1 && windows_seen != sng_pkg::WIN_MAX) windows_seen++;
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  // input side: acceptance at the rising edge, next offer at the falling edge
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      awaited_results.push_back(gate_predict(bins_to_send[0]));
      void'(bins_to_send.pop_front());
      in_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_taken) begin
      in_tvalid <= 1'b1;
    end else if (bins_to_send.size() > 0 && $urandom_range(99) >= tx_idle) begin
      in_tvalid <= 1'b1;
      in_tdata  <= {6'b0, bins_to_send[0].amp, bins_to_send[0].bin};
      in_tuser  <= bins_to_send[0].op;
    end else begin
      in_tvalid <= 1'b0;
    end
    in_taken = 1'b0;
  end

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle);
    end
  end

  // result side and watchdog
  always @(posedge clk) begin
    gate_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result transfer: tdata %h", out_tdata);
        errors++;
      end else begin
        want = awaited_results.pop_front();
        if (out_tdata[23:0] !== want.amp) begin
          $error("amplitude_out: expected %h, actual %h", want.amp, out_tdata[23:0]);
          errors++;
        end
        if (out_tdata[24] !== want.gated) begin
          $error("gated: expected %b, actual %b", want.gated, out_tdata[24]);
          errors++;
        end
        if (out_tdata[25] !== want.no_marks) begin
          $error("no_marks: expected %b, actual %b", want.no_marks, out_tdata[25]);
          errors++;
        end
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic settle();
    do @(posedge clk);
    while (bins_to_send.size() != 0 || in_tvalid || awaited_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [sng_pkg::CFG_BITS-1:0] value);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    case (idx)
      sng_pkg::REG_CLEAN_MODE:   cur_mode   = value[1:0];
      sng_pkg::REG_NOISE_GAIN:   cur_gain   = value[15:0];
      sng_pkg::REG_CUTOFF_BIN:   cur_cutoff = value[10:0];
      sng_pkg::REG_SKIP_WINDOWS: cur_skip   = value[23:0];
      sng_pkg::REG_BIN_COUNT:    cur_bins   = value[10:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wen <= 1'b0;
    #1;
  endtask

  task automatic send(logic [1:0] op, logic [9:0] bin, logic [23:0] amp);
    bin_item_t it;
    it.op = op;
    it.bin = bin;
    it.amp = amp;
    bins_to_send.push_back(it);
  endtask

  function automatic logic [23:0] pick_amp(logic [23:0] mask);
    int r;
    r = $urandom_range(99);
    if (r < 5) return 24'hFFFFFF;
    if (r < 10) return 24'h0;
    return 24'($urandom) & mask;
  endfunction

  task automatic random_phase(int n_items);
    int          cnt;
    int          nb;
    int          len;
    int          r;
    logic [1:0]  op;
    logic [9:0]  bin;
    logic [23:0] mask;
    cnt = 0;
    nb = (cur_bins > NBINS) ? NBINS : cur_bins;
    mask = 24'((64'd1 << $urandom_range(1, 24)) - 1);
    while (cnt < n_items) begin
      r = $urandom_range(99);
      if (r < 15 || nb == 0 || nb > 32) begin
        op = ($urandom_range(99) < 5) ? sng_pkg::OP_RSVD : 2'($urandom_range(2));
        if (nb > 0 && $urandom_range(1)) bin = 10'($urandom_range(nb - 1));
        else bin = 10'($urandom_range(NBINS - 1));
        send(op, bin, pick_amp(mask));
        cnt++;
      end else begin
        op = (r < 35) ? sng_pkg::OP_NOISE : (r < 50) ? sng_pkg::OP_CMP : sng_pkg::OP_SRC;
        len = ($urandom_range(9) == 0) ? $urandom_range(1, nb) : nb;
        for (int b = 0; b < len; b++) send(op, 10'(b), pick_amp(mask));
        cnt += len;
      end
    end
  endtask

  initial begin
    int r;
    logic [10:0] nbins;
    for (int i = 0; i < NBINS; i++) begin
      bin_peak[i] = '0;
      bin_armed[i] = 1'b1;
      bin_stuck[i] = 1'b0;
    end
    disarmed_count = 0;
    windows_seen = '0;
    cur_mode = sng_pkg::MODE_FILTER;
    cur_gain = 16'd256;
    cur_cutoff = '0;
    cur_skip = '0;
    cur_bins = 11'd1024;
    tx_idle = 32;
    rx_idle = 50;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // filtering: peaks, equality at the threshold, bins out of use, unknown opcode
    cfg_write(sng_pkg::REG_BIN_COUNT, 24'd4);
    cfg_write(sng_pkg::REG_NOISE_GAIN, 24'd256);
    cfg_write(sng_pkg::REG_CUTOFF_BIN, 24'd0);
    cfg_write(sng_pkg::REG_SKIP_WINDOWS, 24'd0);
    cfg_write(sng_pkg::REG_CLEAN_MODE, 24'(sng_pkg::MODE_FILTER));
    send(sng_pkg::OP_NOISE, 10'd0, 24'hFFFFFF);
    send(sng_pkg::OP_NOISE, 10'd1, 24'd0);
    send(sng_pkg::OP_NOISE, 10'd2, 24'd100);
    send(sng_pkg::OP_NOISE, 10'd3, 24'd50);
    send(sng_pkg::OP_NOISE, 10'd3, 24'd40);
    send(sng_pkg::OP_SRC, 10'd0, 24'hFFFFFF);
    send(sng_pkg::OP_SRC, 10'd0, 24'hFFFFFE);
    send(sng_pkg::OP_SRC, 10'd1, 24'd0);
    send(sng_pkg::OP_SRC, 10'd2, 24'd99);
    send(sng_pkg::OP_SRC, 10'd3, 24'd60);
    send(sng_pkg::OP_SRC, 10'd5, 24'd7);
    send(sng_pkg::OP_SRC, 10'd1023, 24'hFFFFFF);
    send(sng_pkg::OP_RSVD, 10'd1, 24'd123);
    send(sng_pkg::OP_CMP, 10'd2, 24'd200);
    settle();

    // comparing: clear marks one by one until none is left
    cfg_write(sng_pkg::REG_CLEAN_MODE, 24'(sng_pkg::MODE_COMPARE));
    cfg_write(sng_pkg::REG_NOISE_GAIN, 24'd0);
    send(sng_pkg::OP_CMP, 10'd1, 24'd1);
    send(sng_pkg::OP_SRC, 10'd0, 24'd5);
    send(sng_pkg::OP_SRC, 10'd1, 24'd5);
    send(sng_pkg::OP_CMP, 10'd0, 24'd1);
    send(sng_pkg::OP_CMP, 10'd2, 24'd1);
    send(sng_pkg::OP_CMP, 10'd3, 24'd1);
    send(sng_pkg::OP_SRC, 10'd2, 24'd9);
    settle();

    // from time with latching, widest gain and cutoff
    cfg_write(sng_pkg::REG_CLEAN_MODE, 24'(sng_pkg::MODE_FROMTIME));
    cfg_write(sng_pkg::REG_NOISE_GAIN, 24'hFFFF);
    cfg_write(sng_pkg::REG_SKIP_WINDOWS, 24'd1);
    cfg_write(sng_pkg::REG_CUTOFF_BIN, 24'd1024);
    send(sng_pkg::OP_SRC, 10'd2, 24'd50);
    send(sng_pkg::OP_SRC, 10'd2, 24'hFFFFFF);
    send(sng_pkg::OP_SRC, 10'd3, 24'hFFFFFF);
    settle();

    // no bin in use
    cfg_write(sng_pkg::REG_BIN_COUNT, 24'd0);
    cfg_write(sng_pkg::REG_SKIP_WINDOWS, 24'hFFFFFF);
    cfg_write(sng_pkg::REG_CLEAN_MODE, 24'(sng_pkg::MODE_ANYWHERE));
    send(sng_pkg::OP_SRC, 10'd0, 24'd0);
    send(sng_pkg::OP_NOISE, 10'd0, 24'd1);
    settle();

    for (int ph = 0; ph < 12; ph++) begin
      if (ph < 4) begin
        tx_idle = 32;
        rx_idle = 50;
      end else if (ph < 8) begin
        tx_idle = 50;
        rx_idle = 32;
      end else begin
        tx_idle = 0;
        rx_idle = 0;
      end
      cfg_write(sng_pkg::REG_CLEAN_MODE, 24'($urandom_range(3)));
      r = $urandom_range(99);
      cfg_write(sng_pkg::REG_NOISE_GAIN, (r < 10) ? 24'd0 : (r < 20) ? 24'hFFFF :
                                         24'($urandom_range(64, 1024)));
      r = $urandom_range(99);
      if (ph == 11 || r < 10) nbins = 11'd1024;
      else if (r < 15) nbins = 11'd0;
      else if (r < 20) nbins = 11'd1;
      else nbins = 11'($urandom_range(2, 16));
      cfg_write(sng_pkg::REG_BIN_COUNT, 24'(nbins));
      r = $urandom_range(99);
      cfg_write(sng_pkg::REG_CUTOFF_BIN,
                (r < 10) ? 24'd1024 : 24'($urandom_range(0, nbins)));
      r = $urandom_range(99);
      cfg_write(sng_pkg::REG_SKIP_WINDOWS, (r < 10) ? 24'hFFFFFF : (r < 50) ? 24'd0 :
                                           24'($urandom_range(1, 4)));
      if (ph == 8) hold_req = 1'b1;
      random_phase(85);
      settle();
    end

    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
